// ===== rtl/core/stftfw_pkg.sv =====
`default_nettype none

package stftfw_pkg;

    localparam int OUT_BITS = 23;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic signed [23:0] OUT_MAX = 24'sd4194303;
    localparam logic signed [23:0] OUT_MIN = -24'sd4194304;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_WIN_WAIT,
        ST_MAC,
        ST_MAC_WAIT,
        ST_OUT
    } stftfw_state_t;

    // controller to datapath
    typedef struct packed {
        logic samp_we;
        logic ph_clear;
        logic win_issue;
        logic mac_issue;
        logic first;
        logic last;
        logic step_clear;
        logic step_next;
        logic bank_flip;
    } stftfw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic win_done;
        logic bin_ready;
    } stftfw_stat_t;

    // sin(x) in Q15 for x in Q30 over one quadrant, capped at 1.0
    function automatic logic [16:0] sine_poly(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        x2 = (x * x + 64'd536870912) >> 30;
        t = ONE_Q30;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32768)
        begin
            q = 64'd32768;
        end
        return q[16:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stft_forward_sine_window.sv =====
// Forward STFT, sine window, 50 percent overlap.
// Input channel: in_valid / in_stall with one signed sample per request.
// Samples are collected into blocks of HALF_WINDOW. The request that
// completes a block starts a transform over the previous block and the
// new one (2*HALF_WINDOW points); the first frame after reset sees an
// all-zero previous block.
// Output channel: out_valid / out_stall, HALF_WINDOW+1 requests per frame,
// bins 0 to HALF_WINDOW, frame_last high on the final bin.
// A sample that does not complete a block is taken without a stall.
// After the completing request a windowing pass runs, then each bin is
// computed on one multiply-accumulate pipeline (two multipliers, real and
// imaginary).
// in_stall stays high from the completing sample until the last bin leaves.
// A stalled receiver holds the current bin on the ports and pauses the
// transform. Reset clears the block fill, the bank flags and all control.
`default_nettype none

module stft_forward_sine_window #(
    parameter int HALF_WINDOW = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [5:0]              bin_index,
    output logic signed [22:0]      bin_real,
    output logic signed [22:0]      bin_imag,
    output logic                    frame_last
);

    localparam int KW = $clog2(HALF_WINDOW+1);

    stftfw_pkg::stftfw_cmd_t cmd;
    stftfw_pkg::stftfw_stat_t stat;
    logic signed [SAMPLE_BITS-1:0] samp_x;
    logic [$clog2(HALF_WINDOW)-1:0] fill_idx;
    logic [$clog2(2*HALF_WINDOW)-1:0] mac_n;
    logic [KW-1:0] bin_k;
    logic [stftfw_pkg::OUT_BITS-1:0] res_real, res_imag;

    // up to 16 bits: take the low SAMPLE_BITS bits as a signed sample; wider: zero-extend
    if (SAMPLE_BITS <= 16)
    begin : g_narrow
        assign samp_x = $signed(sample[SAMPLE_BITS-1:0]);
    end
    else
    begin : g_wide
        assign samp_x = $signed({(SAMPLE_BITS-16)'(0), sample});
    end

    stftfw_ctrl #(
        .HALF_WINDOW(HALF_WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd),
        .fill_idx (fill_idx),
        .mac_n    (mac_n),
        .bin_k    (bin_k),
        .bin_last (frame_last)
    );

    stftfw_dp #(
        .HALF_WINDOW(HALF_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .samp_x  (samp_x),
        .fill_idx(fill_idx),
        .mac_n   (mac_n),
        .res_real(res_real),
        .res_imag(res_imag)
    );

    assign bin_index = 6'(bin_k);
    assign bin_real  = $signed(res_real);
    assign bin_imag  = $signed(res_imag);

endmodule

`default_nettype wire

// ===== rtl/core/stftfw_ctrl.sv =====
`default_nettype none

module stftfw_ctrl #(
    parameter int HALF_WINDOW = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    input  wire stftfw_pkg::stftfw_stat_t        stat,
    output stftfw_pkg::stftfw_cmd_t              cmd,
    output logic [$clog2(HALF_WINDOW)-1:0]       fill_idx,
    output logic [$clog2(2*HALF_WINDOW)-1:0]     mac_n,
    output logic [$clog2(HALF_WINDOW+1)-1:0]     bin_k,
    output logic                                 bin_last
);

    localparam int AS = $clog2(HALF_WINDOW);
    localparam int NW = $clog2(2*HALF_WINDOW);
    localparam int KW = $clog2(HALF_WINDOW+1);
    localparam logic [AS-1:0] FILL_END = AS'(HALF_WINDOW-1);
    localparam logic [NW-1:0] N_END = NW'(2*HALF_WINDOW-1);
    localparam logic [KW-1:0] K_END = KW'(HALF_WINDOW);

    stftfw_pkg::stftfw_state_t state_reg, state_next;
    logic [AS-1:0] fill_reg, fill_next;
    logic [NW-1:0] n_reg, n_next;
    logic [KW-1:0] k_reg, k_next;
    logic full, n_last, k_last;

    assign full   = (fill_reg == FILL_END);
    assign n_last = (n_reg == N_END);
    assign k_last = (k_reg == K_END);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stftfw_pkg::ST_IDLE:
            begin
                if (in_valid && full)
                begin
                    state_next = stftfw_pkg::ST_WIN;
                end
            end
            stftfw_pkg::ST_WIN:
            begin
                if (n_last)
                begin
                    state_next = stftfw_pkg::ST_WIN_WAIT;
                end
            end
            stftfw_pkg::ST_WIN_WAIT:
            begin
                if (stat.win_done)
                begin
                    state_next = stftfw_pkg::ST_MAC;
                end
            end
            stftfw_pkg::ST_MAC:
            begin
                if (n_last)
                begin
                    state_next = stftfw_pkg::ST_MAC_WAIT;
                end
            end
            stftfw_pkg::ST_MAC_WAIT:
            begin
                if (stat.bin_ready)
                begin
                    state_next = stftfw_pkg::ST_OUT;
                end
            end
            stftfw_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = k_last ? stftfw_pkg::ST_IDLE : stftfw_pkg::ST_MAC;
                end
            end
            default:
            begin
                state_next = stftfw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.samp_we    = (state_reg == stftfw_pkg::ST_IDLE) && in_valid;
        cmd.step_clear = cmd.samp_we && full;
        cmd.step_next  = (state_reg == stftfw_pkg::ST_OUT) && !out_stall && !k_last;
        cmd.bank_flip  = (state_reg == stftfw_pkg::ST_WIN_WAIT) && stat.win_done;
        cmd.ph_clear   = cmd.step_clear || cmd.bank_flip || cmd.step_next;
        cmd.win_issue  = (state_reg == stftfw_pkg::ST_WIN);
        cmd.mac_issue  = (state_reg == stftfw_pkg::ST_MAC);
        cmd.first      = (n_reg == '0);
        cmd.last       = n_last;
        in_stall       = (state_reg != stftfw_pkg::ST_IDLE);
        out_valid      = (state_reg == stftfw_pkg::ST_OUT);
    end

    always_comb
    begin
        fill_next = fill_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        if (cmd.samp_we)
        begin
            fill_next = full ? '0 : fill_reg + AS'(1);
        end
        if (cmd.win_issue || cmd.mac_issue)
        begin
            n_next = n_last ? '0 : n_reg + NW'(1);
        end
        if (cmd.bank_flip)
        begin
            k_next = '0;
        end
        else if (cmd.step_next)
        begin
            k_next = k_reg + KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stftfw_pkg::ST_IDLE;
            fill_reg  <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
        end
    end

    assign fill_idx = fill_reg;
    assign mac_n    = n_reg;
    assign bin_k    = k_reg;
    assign bin_last = k_last;

endmodule

`default_nettype wire

// ===== rtl/core/stftfw_dp.sv =====
`default_nettype none

module stftfw_dp #(
    parameter int HALF_WINDOW = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire stftfw_pkg::stftfw_cmd_t             cmd,
    output stftfw_pkg::stftfw_stat_t                 stat,
    input  wire logic signed [SAMPLE_BITS-1:0]       samp_x,
    input  wire logic [$clog2(HALF_WINDOW)-1:0]      fill_idx,
    input  wire logic [$clog2(2*HALF_WINDOW)-1:0]    mac_n,
    output logic [stftfw_pkg::OUT_BITS-1:0]          res_real,
    output logic [stftfw_pkg::OUT_BITS-1:0]          res_imag
);

    localparam int N  = HALF_WINDOW;
    localparam int SB = SAMPLE_BITS;
    localparam int AS = $clog2(N);
    localparam int RW = $clog2(N+1);
    localparam int NW = $clog2(2*N);
    localparam int PW = SB + 17;
    localparam int AW = PW + NW + 1;
    localparam int RB = (AW - 14 > 24) ? AW - 14 : 24;
    localparam logic [RW:0] N_R = (RW+1)'(N);

    // quarter-wave sine table, built at elaboration
    logic [16:0] qtab [0:N];
    for (genvar gi = 0; gi <= N; gi++)
    begin : g_qtab
        localparam logic [63:0] XV =
            (stftfw_pkg::PI_HALF_Q30 * 64'(gi) + 64'(N/2)) / 64'(N);
        assign qtab[gi] = stftfw_pkg::sine_poly(XV);
    end

    function automatic logic signed [16:0] twid(input logic [1:0] q, input logic [RW-1:0] r);
        logic [RW-1:0] rr;
        logic [16:0] m;
        rr = q[0] ? RW'(N_R[RW-1:0] - r) : r;
        m = qtab[rr];
        return q[1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [stftfw_pkg::OUT_BITS-1:0] round_sat(input logic signed [AW-1:0] a);
        logic neg;
        logic [AW-1:0] mag;
        logic [AW:0] rs;
        logic signed [RB-1:0] sv;
        neg = a[AW-1];
        mag = neg ? AW'(-a) : AW'(a);
        rs = {1'b0, mag} + (AW+1)'(16384);
        sv = neg ? -$signed(RB'(rs[AW:15])) : $signed(RB'(rs[AW:15]));
        if (sv > RB'(stftfw_pkg::OUT_MAX))
        begin
            sv = RB'(stftfw_pkg::OUT_MAX);
        end
        else if (sv < RB'(stftfw_pkg::OUT_MIN))
        begin
            sv = RB'(stftfw_pkg::OUT_MIN);
        end
        return sv[stftfw_pkg::OUT_BITS-1:0];
    endfunction

    // sample banks: one holds the current block, the other the previous one
    logic [SB-1:0] mem_a [0:N-1];
    logic [SB-1:0] mem_b [0:N-1];
    logic [SB-1:0] tmem [0:2*N-1];
    logic bank_reg;
    logic [1:0] written_reg;

    // phase as quadrant and residue, residue below N
    logic [1:0] ph_q_reg, step_q_reg, inc_q, ph_q_next;
    logic [RW-1:0] ph_r_reg, step_r_reg, inc_r, ph_r_next;
    logic [RW:0] ph_sum, step_sum;

    logic [SB-1:0] a_rd_reg, b_rd_reg, y_rd_reg;
    logic signed [16:0] cos_reg, sin_reg;
    logic s1_v_reg, s1_win_reg, s1_first_reg, s1_last_reg, s1_bank_reg;
    logic s2_v_reg, s2_win_reg, s2_first_reg, s2_last_reg;
    logic signed [PW-1:0] p_re_reg, p_im_reg;
    logic signed [AW-1:0] acc_re_reg, acc_im_reg;
    logic acc_done_reg;
    logic [NW-1:0] wr_n_reg;
    logic [stftfw_pkg::OUT_BITS-1:0] res_re_reg, res_im_reg;

    logic issue, rd_bank;
    logic signed [SB-1:0] x_sel, mul_a;
    logic [PW-1:0] w_mag;
    logic [PW:0] w_rs;
    logic [SB-1:0] y_val;

    assign issue   = cmd.win_issue || cmd.mac_issue;
    assign rd_bank = ph_q_reg[0] ? bank_reg : ~bank_reg;
    assign inc_q   = cmd.win_issue ? 2'd0 : step_q_reg;
    assign inc_r   = cmd.win_issue ? RW'(1) : step_r_reg;

    always_comb
    begin
        ph_sum = {1'b0, ph_r_reg} + {1'b0, inc_r};
        ph_q_next = ph_q_reg + inc_q;
        ph_r_next = ph_sum[RW-1:0];
        if (ph_sum >= N_R)
        begin
            ph_r_next = RW'(ph_sum - N_R);
            ph_q_next = ph_q_reg + inc_q + 2'd1;
        end
        step_sum = {1'b0, step_r_reg} + (RW+1)'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_q_reg    <= '0;
            ph_r_reg    <= '0;
            step_q_reg  <= '0;
            step_r_reg  <= '0;
            bank_reg    <= 1'b0;
            written_reg <= '0;
            wr_n_reg    <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            acc_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ph_clear)
            begin
                ph_q_reg <= '0;
                ph_r_reg <= '0;
            end
            else if (issue)
            begin
                ph_q_reg <= ph_q_next;
                ph_r_reg <= ph_r_next;
            end
            if (cmd.step_clear)
            begin
                step_q_reg <= '0;
                step_r_reg <= '0;
            end
            else if (cmd.step_next)
            begin
                if (step_sum >= N_R)
                begin
                    step_r_reg <= RW'(step_sum - N_R);
                    step_q_reg <= step_q_reg + 2'd1;
                end
                else
                begin
                    step_r_reg <= step_sum[RW-1:0];
                end
            end
            if (cmd.samp_we)
            begin
                written_reg[bank_reg] <= 1'b1;
            end
            if (cmd.bank_flip)
            begin
                bank_reg <= ~bank_reg;
            end
            if (s2_v_reg && s2_win_reg)
            begin
                wr_n_reg <= s2_last_reg ? '0 : wr_n_reg + NW'(1);
            end
            s1_v_reg     <= issue;
            s2_v_reg     <= s1_v_reg;
            acc_done_reg <= s2_v_reg && !s2_win_reg && s2_last_reg;
        end
    end

    // memories and payload stages
    always_ff @(posedge clk)
    begin
        if (cmd.samp_we && !bank_reg)
        begin
            mem_a[fill_idx] <= samp_x;
        end
        if (cmd.samp_we && bank_reg)
        begin
            mem_b[fill_idx] <= samp_x;
        end
        a_rd_reg <= mem_a[ph_r_reg[AS-1:0]];
        b_rd_reg <= mem_b[ph_r_reg[AS-1:0]];
        y_rd_reg <= tmem[mac_n];
        sin_reg  <= twid(ph_q_reg, ph_r_reg);
        cos_reg  <= twid(ph_q_reg + 2'd1, ph_r_reg);
        s1_win_reg   <= cmd.win_issue;
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_bank_reg  <= rd_bank;
        p_re_reg <= mul_a * cos_reg;
        p_im_reg <= mul_a * sin_reg;
        s2_win_reg   <= s1_win_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        if (s2_v_reg && s2_win_reg)
        begin
            tmem[wr_n_reg] <= y_val;
        end
        if (s2_v_reg && !s2_win_reg)
        begin
            acc_re_reg <= (s2_first_reg ? AW'(0) : acc_re_reg) + AW'(p_re_reg);
            acc_im_reg <= (s2_first_reg ? AW'(0) : acc_im_reg) - AW'(p_im_reg);
        end
        if (acc_done_reg)
        begin
            res_re_reg <= round_sat(acc_re_reg);
            res_im_reg <= round_sat(acc_im_reg);
        end
    end

    always_comb
    begin
        x_sel = '0;
        if (written_reg[s1_bank_reg])
        begin
            x_sel = s1_bank_reg ? $signed(b_rd_reg) : $signed(a_rd_reg);
        end
        mul_a = s1_win_reg ? x_sel : $signed(y_rd_reg);
        // windowed sample: divide by 2^15, round half away from zero
        w_mag = p_im_reg[PW-1] ? PW'(-p_im_reg) : PW'(p_im_reg);
        w_rs  = {1'b0, w_mag} + (PW+1)'(16384);
        y_val = p_im_reg[PW-1] ? SB'(-w_rs[PW:15]) : SB'(w_rs[PW:15]);
    end

    assign stat.win_done  = s2_v_reg && s2_win_reg && s2_last_reg;
    assign stat.bin_ready = acc_done_reg;
    assign res_real = res_re_reg;
    assign res_imag = res_im_reg;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    localparam int HALF = 32;
    localparam int FRAME = 2 * HALF;
    localparam int LIMIT = 3000000;
    localparam int HOLD_LEN = 2500;
    localparam logic [63:0] PI_HALF = 64'd1686629713;
    localparam logic [63:0] ONE = 64'd1073741824;

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [22:0] re;
        logic signed [22:0] im;
        logic               last;
    } bin_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample;
    logic               out_valid;
    logic               out_stall;
    logic [5:0]         bin_index;
    logic signed [22:0] bin_real;
    logic signed [22:0] bin_imag;
    logic               frame_last;

    // predictor state
    int   prev_blk [HALF];
    int   cur_blk [HALF];
    int   fill;
    int   sine_tab [4 * HALF];
    bin_t bins_due [$];

    int   errors;
    int   cycles;
    int   requests_sent;
    int   bins_seen;
    int   frames_seen;
    bit   hold_off;   // long receiver hold-off request
    int   hold_cnt;   // cycles the long hold-off has run
    int   gap_max;    // longest sender gap
    int   stall_pct;  // receiver stall chance in percent

    stft_forward_sine_window i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .bin_real   (bin_real),
        .bin_imag   (bin_imag),
        .frame_last (frame_last)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Q15 sine over one quadrant, Taylor series in Q30 with truncating steps
    function automatic int quarter_q15(input int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] divs [5];
        divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        x = (PI_HALF * 64'(r) + 64'(HALF / 2)) / 64'(HALF);
        x2 = (x * x + 64'd536870912) >> 30;
        t = ONE;
        for (int i = 0; i < 5; i++)
        begin
            t = ONE - ((x2 * t) >> 30) / divs[i];
        end
        s = (x * t) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32768)
        begin
            q = 64'd32768;
        end
        return int'(q);
    endfunction

    function automatic longint scale_q15(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 16384) >>> 15;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [22:0] clip23(input longint v);
        if (v > 4194303)
        begin
            return 23'sd4194303;
        end
        if (v < -4194304)
        begin
            return -23'sd4194304;
        end
        return v[22:0];
    endfunction

    // Window the frame, run the DFT, queue the N+1 bins.
    task automatic frame_spectrum();
        longint y [FRAME];
        longint sum_re;
        longint sum_im;
        int     p;
        bin_t   b;
        for (int n = 0; n < FRAME; n++)
        begin
            y[n] = scale_q15(longint'(n < HALF ? prev_blk[n] : cur_blk[n - HALF])
                             * sine_tab[n]);
        end
        for (int k = 0; k <= HALF; k++)
        begin
            sum_re = 0;
            sum_im = 0;
            for (int n = 0; n < FRAME; n++)
            begin
                p = (2 * k * n) % (4 * HALF);
                sum_re += y[n] * sine_tab[(p + HALF) % (4 * HALF)];
                sum_im -= y[n] * sine_tab[p];
            end
            b.idx = 6'(k);
            b.re = clip23(scale_q15(sum_re));
            b.im = clip23(scale_q15(sum_im));
            b.last = (k == HALF);
            bins_due.push_back(b);
        end
        prev_blk = cur_blk;
    endtask

    task automatic absorb_sample(input logic signed [15:0] s);
        cur_blk[fill] = int'(s);
        fill++;
        if (fill == HALF)
        begin
            fill = 0;
            frame_spectrum();
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d, expected %0d (bin %0d of frame %0d)",
                 what, got, want, bins_seen % (HALF + 1), frames_seen);
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_sample(input logic signed [15:0] s);
        in_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        absorb_sample(s);
        requests_sent++;
        if (gap_max > 0 && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            sample <= 16'($urandom);
            repeat ($urandom_range(gap_max, 1)) @(posedge clk);
        end
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        while (bins_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Table of Q15 sines at angles 2*pi*p/(4N).
    task automatic build_sines();
        int qd;
        int r;
        int mag;
        for (int p = 0; p < 4 * HALF; p++)
        begin
            qd = p / HALF;
            r = p % HALF;
            if (qd & 1)
            begin
                r = HALF - r;
            end
            mag = quarter_q15(r);
            sine_tab[p] = (qd & 2) ? -mag : mag;
        end
    endtask

    // Extremes, impulses and a full-scale square wave; the first frame after
    // reset sees an all-zero previous block.
    task automatic test_directed();
        for (int i = 0; i < HALF; i++)
        begin
            send_sample(i == 0 ? 16'sh7fff : (i == 1 ? 16'sh8000 : 16'sh0000));
        end
        for (int i = 0; i < HALF; i++)
        begin
            send_sample((i % 2) ? 16'sh8000 : 16'sh7fff);
        end
        pause_sender();
    endtask

    // Full-scale constant input pushes the DC bin to its largest magnitude.
    task automatic test_saturation();
        repeat (2 * HALF) send_sample(16'sh8000);
        repeat (2 * HALF) send_sample(16'sh7fff);
        pause_sender();
    endtask

    task automatic test_random(input int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(3);
            case (kind)
                0: send_sample(16'($urandom));
                1: send_sample($urandom_range(1) ? 16'sh7fff : 16'sh8000);
                2: send_sample(16'($signed(10'($urandom))));
                default: send_sample(16'($urandom_range(65535)));
            endcase
        end
    endtask

    // Receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(3 * HALF);
        hold_off = 1'b0;
        pause_sender();
    endtask

    // Receiver: random stalls, with one long counted hold-off when asked.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_off && hold_cnt < HOLD_LEN)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check each accepted bin against the oldest expectation.
    always @(posedge clk)
    begin
        bin_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bins_due.size() == 0)
            begin
                report("bin with nothing due", bin_index, 0);
            end
            else
            begin
                want = bins_due.pop_front();
                if (bin_index !== want.idx)
                begin
                    report("bin_index", bin_index, want.idx);
                end
                if (bin_real !== want.re)
                begin
                    report("bin_real", bin_real, want.re);
                end
                if (bin_imag !== want.im)
                begin
                    report("bin_imag", bin_imag, want.im);
                end
                if (frame_last !== want.last)
                begin
                    report("frame_last", frame_last, want.last);
                end
                bins_seen++;
                if (want.last)
                begin
                    frames_seen++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        errors = 0;
        cycles = 0;
        fill = 0;
        requests_sent = 0;
        bins_seen = 0;
        frames_seen = 0;
        hold_off = 1'b0;
        gap_max = 0;
        stall_pct = 0;
        foreach (prev_blk[i])
        begin
            prev_blk[i] = 0;
            cur_blk[i] = 0;
        end
        build_sines();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        stall_pct = 30;
        gap_max = 4;
        test_saturation();
        test_backpressure();
        gap_max = 0;
        stall_pct = 0;
        test_random(4 * HALF);
        gap_max = 20;
        stall_pct = 60;
        test_random(4 * HALF);
        pause_sender();

        repeat (200) @(posedge clk);
        $display("covered %0d samples, %0d frames, %0d bins checked",
                 requests_sent, frames_seen, bins_seen);
        $display("with random bursts, receiver stalls and a long output hold-off");
        if (errors == 0 && bins_due.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d errors, %0d bins missing", errors, bins_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
